### rtl/core/plte_pkg.sv
// Package for the pc/line table encoder: constants, byte selects, FSM states
// and the command/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package plte_pkg;

  localparam int unsigned MaxPcBytesDefault = 16;

  localparam int unsigned AddrWidth = 32;
  localparam int unsigned LineWidth = 31;
  localparam int unsigned HalvesWidth = AddrWidth - 1;

  localparam logic [7:0] ChunkMax = 8'd127;
  localparam logic [7:0] PadByte = 8'd129;
  localparam logic [31:0] ShortRange = 32'd64;
  localparam logic [AddrWidth-1:0] HalfWord = 32'd2;

  typedef enum logic [3:0] {
    SelChunk,
    SelShort,
    SelZero,
    SelB3,
    SelB2,
    SelB1,
    SelB0,
    SelPad,
    SelOvf
  } byte_sel_e;

  typedef enum logic [3:0] {
    StIdle,
    StEval,
    StChunk,
    StShort,
    StLongZ,
    StLong3,
    StLong2,
    StLong1,
    StLong0,
    StPad,
    StOvf
  } state_e;

  typedef struct packed {
    logic      load;
    logic      emit;
    byte_sel_e sel;
    logic      last;
    logic      chunk_step;
    logic      commit;
    logic      restart;
  } cmd_t;

  typedef struct packed {
    logic encode;
    logic endp;
    logic ovf;
    logic halves_zero;
    logic last_chunk;
    logic short_delta;
    logic odd;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

### rtl/core/plte_ctrl.sv
// Controller for the pc/line table encoder: sequences the bytes of one item.
// Depends on plte_pkg; drives the plte_dp datapath through cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module plte_ctrl
  import plte_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  state_e state_q, state_d;

  // last byte of the line delta ends the run unless padding follows
  logic line_last;
  assign line_last = !(status_i.endp && !status_i.odd);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) state_d = StEval;
      end
      StEval: begin
        if (!status_i.encode) begin
          state_d = (status_i.endp && status_i.odd) ? StPad : StIdle;
        end else if (status_i.ovf) begin
          state_d = StOvf;
        end else if (!status_i.halves_zero) begin
          state_d = StChunk;
        end else begin
          state_d = status_i.short_delta ? StShort : StLongZ;
        end
      end
      StChunk: begin
        if (status_i.out_free && status_i.last_chunk) begin
          state_d = status_i.short_delta ? StShort : StLongZ;
        end
      end
      StShort, StLong0: begin
        if (status_i.out_free) state_d = line_last ? StIdle : StPad;
      end
      StLongZ: if (status_i.out_free) state_d = StLong3;
      StLong3: if (status_i.out_free) state_d = StLong2;
      StLong2: if (status_i.out_free) state_d = StLong1;
      StLong1: if (status_i.out_free) state_d = StLong0;
      StPad, StOvf: begin
        if (status_i.out_free) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.sel = SelChunk;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      StEval: begin
        if (!status_i.encode) begin
          cmd_o.restart = status_i.endp && !status_i.odd;
        end else if (!status_i.ovf) begin
          cmd_o.commit = 1'b1;
        end
      end
      StChunk: begin
        cmd_o.emit = status_i.out_free;
        cmd_o.sel = SelChunk;
        cmd_o.chunk_step = status_i.out_free;
      end
      StShort, StLong0: begin
        cmd_o.emit = status_i.out_free;
        cmd_o.sel = (state_q == StShort) ? SelShort : SelB0;
        cmd_o.last = line_last;
        cmd_o.restart = status_i.out_free && status_i.endp && line_last;
      end
      StLongZ: begin
        cmd_o.emit = status_i.out_free;
        cmd_o.sel = SelZero;
      end
      StLong3: begin
        cmd_o.emit = status_i.out_free;
        cmd_o.sel = SelB3;
      end
      StLong2: begin
        cmd_o.emit = status_i.out_free;
        cmd_o.sel = SelB2;
      end
      StLong1: begin
        cmd_o.emit = status_i.out_free;
        cmd_o.sel = SelB1;
      end
      StPad: begin
        cmd_o.emit = status_i.out_free;
        cmd_o.sel = SelPad;
        cmd_o.last = 1'b1;
        cmd_o.restart = status_i.out_free;
      end
      StOvf: begin
        cmd_o.emit = status_i.out_free;
        cmd_o.sel = SelOvf;
        cmd_o.last = 1'b1;
      end
      default: begin
        cmd_o = '0;
        cmd_o.sel = SelChunk;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/plte_dp.sv
// Datapath for the pc/line table encoder: table state, item registers,
// advance counter, byte selection and the output register.
// Depends on plte_pkg; commanded by plte_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module plte_dp
  import plte_pkg::*;
#(
  parameter int unsigned MaxPcBytes = MaxPcBytesDefault
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic [AddrWidth-1:0] instr_address_i,
  input  wire logic [LineWidth-1:0] source_line_i,
  input  wire logic                 skip_entry_i,
  input  wire logic                 end_of_program_i,
  input  wire logic                 cfg_we_i,
  input  wire logic [AddrWidth-1:0] cfg_wdata_i,
  input  wire logic                 out_ready_i,
  output logic                      out_valid_o,
  output logic [7:0]                table_byte_o,
  output logic                      last_of_run_o,
  output logic                      overflow_o,
  input  wire cmd_t                 cmd_i,
  output status_t                   status_o
);

  localparam int unsigned LimitInt = 127 * MaxPcBytes;
  localparam logic [HalvesWidth-1:0] HalvesLimit = HalvesWidth'(LimitInt);

  logic [AddrWidth-1:0]   text_base_q, prev_addr_q, prev_addr_d;
  logic [LineWidth-1:0]   prev_line_q, prev_line_d;
  logic                   odd_q, odd_d;
  logic [AddrWidth-1:0]   addr_q;
  logic [LineWidth-1:0]   line_q;
  logic                   endp_q, enc_q;
  logic [HalvesWidth-1:0] halves_q, halves_d;
  logic [31:0]            delta_q;
  logic                   out_valid_q, out_valid_d;
  logic [7:0]             byte_q, byte_d;
  logic                   last_q, ovf_q;

  logic [AddrWidth-1:0]   addr_diff;
  logic [6:0]             chunk_len;
  logic [7:0]             short_byte;
  logic                   out_free;

  assign addr_diff = instr_address_i - prev_addr_q;
  assign out_free = !out_valid_q || out_ready_i;
  assign status_o.last_chunk = (halves_q <= HalvesWidth'(ChunkMax));
  assign chunk_len = status_o.last_chunk ? halves_q[6:0] : ChunkMax[6:0];
  assign short_byte = (delta_q <= ShortRange) ? delta_q[7:0]
                                              : ShortRange[7:0] - delta_q[7:0];

  assign status_o.encode = enc_q;
  assign status_o.endp = endp_q;
  assign status_o.ovf = (halves_q > HalvesLimit);
  assign status_o.halves_zero = (halves_q == '0);
  assign status_o.short_delta = ((delta_q != '0) && (delta_q <= ShortRange)) ||
                                (delta_q >= (32'd0 - ShortRange));
  assign status_o.odd = odd_q;
  assign status_o.out_free = out_free;

  always_comb begin
    case (cmd_i.sel)
      SelChunk: byte_d = {1'b1, chunk_len};
      SelShort: byte_d = short_byte;
      SelZero:  byte_d = 8'd0;
      SelB3:    byte_d = delta_q[31:24];
      SelB2:    byte_d = delta_q[23:16];
      SelB1:    byte_d = delta_q[15:8];
      SelB0:    byte_d = delta_q[7:0];
      SelPad:   byte_d = PadByte;
      SelOvf:   byte_d = 8'd0;
      default:  byte_d = 8'd0;
    endcase
  end

  always_comb begin
    halves_d = halves_q;
    if (cmd_i.load) begin
      halves_d = addr_diff[AddrWidth-1:1];
    end else if (cmd_i.chunk_step) begin
      halves_d = halves_q - HalvesWidth'(chunk_len);
    end

    prev_addr_d = prev_addr_q;
    prev_line_d = prev_line_q;
    odd_d = odd_q;
    if (cmd_i.commit) begin
      prev_addr_d = addr_q + HalfWord;
      prev_line_d = line_q;
    end
    // every table byte of an encoded item flips the parity
    if (cmd_i.emit && (cmd_i.sel != SelPad) && (cmd_i.sel != SelOvf)) begin
      odd_d = ~odd_q;
    end
    if (cmd_i.restart) begin
      prev_addr_d = text_base_q;
      prev_line_d = '0;
      odd_d = 1'b0;
    end
    if (cfg_we_i) begin
      prev_addr_d = cfg_wdata_i;
    end

    out_valid_d = out_valid_q;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_base_q <= '0;
      prev_addr_q <= '0;
      prev_line_q <= '0;
      odd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) text_base_q <= cfg_wdata_i;
      prev_addr_q <= prev_addr_d;
      prev_line_q <= prev_line_d;
      odd_q       <= odd_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    halves_q <= halves_d;
    if (cmd_i.load) begin
      addr_q  <= instr_address_i;
      line_q  <= source_line_i;
      endp_q  <= end_of_program_i;
      enc_q   <= !skip_entry_i && (source_line_i != prev_line_q);
      delta_q <= {1'b0, source_line_i} - {1'b0, prev_line_q};
    end
    if (cmd_i.emit) begin
      byte_q <= byte_d;
      last_q <= cmd_i.last;
      ovf_q  <= (cmd_i.sel == SelOvf);
    end
  end

  assign out_valid_o = out_valid_q;
  assign table_byte_o = byte_q;
  assign last_of_run_o = last_q;
  assign overflow_o = ovf_q;

endmodule

`default_nettype wire

### rtl/core/pc_line_table_encoder_top.sv
// Top level of the pc/line table encoder: controller plus datapath.
// Depends on plte_pkg, plte_ctrl and plte_dp.
`timescale 1ns / 1ps
`default_nettype none

// Encodes instruction records into pc/line table bytes, one record at a time.
// A record is taken in the idle state and evaluated in the next cycle, and
// then each table byte it produces is loaded in turn into the output
// register, each byte waiting while the output side stalls. The byte
// sequencer in the controller steps through these bytes: the address
// advance is counted down by one chunk of up to 127 half-words per byte.
// An advance beyond MaxPcBytes chunks gives a single overflow result and
// leaves the table state untouched. text_base is written through
// cfg_we_i/cfg_wdata_i, which also reloads the previous address; the user
// writes it only while the block is idle, as the block does not enforce this.
module pc_line_table_encoder_top
  import plte_pkg::*;
#(
  parameter int unsigned MaxPcBytes = MaxPcBytesDefault
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [AddrWidth-1:0] instr_address_i,
  input  wire logic [LineWidth-1:0] source_line_i,
  input  wire logic                 skip_entry_i,
  input  wire logic                 end_of_program_i,
  input  wire logic                 cfg_we_i,
  input  wire logic [AddrWidth-1:0] cfg_wdata_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [7:0]                table_byte_o,
  output logic                      last_of_run_o,
  output logic                      overflow_o
);

  cmd_t    cmd;
  status_t status;

  plte_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  plte_dp #(
    .MaxPcBytes (MaxPcBytes)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .instr_address_i  (instr_address_i),
    .source_line_i    (source_line_i),
    .skip_entry_i     (skip_entry_i),
    .end_of_program_i (end_of_program_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .out_ready_i      (out_ready_i),
    .out_valid_o      (out_valid_o),
    .table_byte_o     (table_byte_o),
    .last_of_run_o    (last_of_run_o),
    .overflow_o       (overflow_o),
    .cmd_i            (cmd),
    .status_o         (status)
  );

endmodule

`default_nettype wire
